// ----- rtl/core/pftr_pkg.sv -----
package pftr_pkg;

	localparam int FRAMES_DEF    = 64;
	localparam int PAGE_BITS_DEF = 12;

	localparam int ADDR_W   = 27;
	localparam int PAGE_W   = 15;
	localparam int FRAME_W  = 6;
	localparam int OFFSET_W = 12;
	localparam int DESC_W   = 16;
	// descriptor: dirty flag on top, page number below
	localparam int DIRTY_POS = 15;

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 56;

	typedef logic [PAGE_W-1:0]   page_t;
	typedef logic [FRAME_W-1:0]  frame_t;
	typedef logic [OFFSET_W-1:0] offset_t;
	typedef logic [DESC_W-1:0]   desc_t;

	// declared msb first, so frame sits in the lowest bits
	typedef struct packed {
		page_t   fill_page;
		logic    fill_request;
		page_t   flush_page;
		logic    flush_request;
		offset_t offset;
		frame_t  frame;
	} result_t;

	localparam int RESULT_W = $bits(result_t);

endpackage

// ----- rtl/core/pftr_desc_ram.sv -----
module pftr_desc_ram #(
	parameter int DEPTH = pftr_pkg::FRAMES_DEF,
	parameter int AW    = $clog2(pftr_pkg::FRAMES_DEF)
) (
	input  logic                  clk,
	input  logic [AW-1:0]         rd_addr,
	output pftr_pkg::desc_t       rd_data,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  pftr_pkg::desc_t       wr_data
);

	pftr_pkg::desc_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

// ----- rtl/core/pftr_seq.sv -----
module pftr_seq #(
	parameter int FRAMES    = pftr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = pftr_pkg::PAGE_BITS_DEF,
	parameter int FW        = $clog2(FRAMES)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          in_action,
	input  logic [pftr_pkg::ADDR_W-1:0]   in_address,
	output logic                          res_valid,
	input  logic                          res_ready,
	output pftr_pkg::result_t             res,
	output logic [FW-1:0]                 mem_rd_addr,
	input  pftr_pkg::desc_t               mem_rd_data,
	output logic                          mem_wr_en,
	output logic [FW-1:0]                 mem_wr_addr,
	output pftr_pkg::desc_t               mem_wr_data
);

	localparam logic [FW-1:0] IDX_ONE   = FW'(1);
	localparam logic [FW-1:0] LAST_IDX  = FW'(FRAMES - 1);
	localparam logic [FW-1:0] VICT_WRAP = FW'(FRAMES - 2);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SCAN,
		ST_VICT,
		ST_MARK,
		ST_EMIT
	} state_t;

	state_t              state_q;
	logic [FW-1:0]       clr_q;
	logic [FW-1:0]       scan_addr_q;
	logic                issue_q;
	logic                cmp_vld_s1;
	logic [FW-1:0]       cmp_addr_s1;
	logic [FW-1:0]       victim_q;
	pftr_pkg::page_t     recent_page_q;
	logic [FW-1:0]       recent_frame_q;
	pftr_pkg::page_t     page_q;
	logic                act_q;
	pftr_pkg::result_t   res_q;

	pftr_pkg::page_t     in_page;
	pftr_pkg::offset_t   in_offset;
	logic                page_match;
	logic                hit_now;
	logic                miss_now;
	logic                old_dirty;

	assign in_page   = pftr_pkg::page_t'(in_address >> PAGE_BITS);
	assign in_offset = pftr_pkg::offset_t'(in_address[PAGE_BITS-1:0]);

	// shared compare unit, fed one descriptor per cycle from the ram
	assign page_match = (mem_rd_data[pftr_pkg::PAGE_W-1:0] == page_q);
	assign hit_now    = (state_q == ST_SCAN) && cmp_vld_s1 && page_match;
	assign miss_now   = (state_q == ST_SCAN) && cmp_vld_s1 && !page_match
		&& (cmp_addr_s1 == LAST_IDX);
	assign old_dirty  = mem_rd_data[pftr_pkg::DIRTY_POS];

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_EMIT);
	assign res       = res_q;

	always_comb begin
		mem_rd_addr = scan_addr_q;
		mem_wr_en   = 1'b0;
		mem_wr_addr = clr_q;
		mem_wr_data = '0;
		case (state_q)
			ST_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			ST_IDLE: begin
				mem_rd_addr = recent_frame_q;
			end
			ST_SCAN: begin
				if (miss_now) begin
					mem_rd_addr = victim_q;
				end
				if (hit_now && act_q) begin
					mem_wr_en   = 1'b1;
					mem_wr_addr = cmp_addr_s1;
					mem_wr_data = {1'b1, mem_rd_data[pftr_pkg::PAGE_W-1:0]};
				end
			end
			ST_VICT: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = victim_q;
				mem_wr_data = {act_q, page_q};
			end
			ST_MARK: begin
				mem_wr_en   = 1'b1;
				mem_wr_addr = recent_frame_q;
				mem_wr_data = {1'b1, mem_rd_data[pftr_pkg::PAGE_W-1:0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_CLEAR;
			clr_q          <= '0;
			scan_addr_q    <= IDX_ONE;
			issue_q        <= 1'b0;
			cmp_vld_s1     <= 1'b0;
			cmp_addr_s1    <= '0;
			victim_q       <= IDX_ONE;
			recent_page_q  <= '0;
			recent_frame_q <= '0;
			page_q         <= '0;
			act_q          <= 1'b0;
			res_q          <= '0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == LAST_IDX) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + IDX_ONE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						act_q               <= in_action;
						page_q              <= in_page;
						res_q.offset        <= in_offset;
						res_q.flush_request <= 1'b0;
						res_q.flush_page    <= '0;
						res_q.fill_request  <= 1'b0;
						res_q.fill_page     <= '0;
						if (in_page == recent_page_q) begin
							res_q.frame <= pftr_pkg::frame_t'(recent_frame_q);
							state_q     <= in_action ? ST_MARK : ST_EMIT;
						end else begin
							recent_page_q <= in_page;
							scan_addr_q   <= IDX_ONE;
							issue_q       <= 1'b1;
							cmp_vld_s1    <= 1'b0;
							state_q       <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					if (hit_now) begin
						res_q.frame    <= pftr_pkg::frame_t'(cmp_addr_s1);
						recent_frame_q <= cmp_addr_s1;
						cmp_vld_s1     <= 1'b0;
						state_q        <= ST_EMIT;
					end else if (miss_now) begin
						cmp_vld_s1 <= 1'b0;
						state_q    <= ST_VICT;
					end else begin
						// one read issued per cycle, compared in the next cycle
						cmp_vld_s1  <= issue_q;
						cmp_addr_s1 <= scan_addr_q;
						if (issue_q) begin
							if (scan_addr_q == LAST_IDX) begin
								issue_q <= 1'b0;
							end else begin
								scan_addr_q <= scan_addr_q + IDX_ONE;
							end
						end
					end
				end
				ST_VICT: begin
					res_q.flush_request <= old_dirty;
					res_q.flush_page    <= old_dirty ?
						mem_rd_data[pftr_pkg::PAGE_W-1:0] : '0;
					res_q.fill_request  <= 1'b1;
					res_q.fill_page     <= page_q;
					res_q.frame         <= pftr_pkg::frame_t'(victim_q);
					recent_frame_q      <= victim_q;
					victim_q            <= (victim_q == VICT_WRAP) ? IDX_ONE :
						victim_q + IDX_ONE;
					state_q             <= ST_EMIT;
				end
				ST_MARK: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- rtl/core/page_frame_translation_round_robin_unit.sv -----
// Page frame translation with a fully associative, round-robin, write-back
// frame table. Each access on the s side (address in s_tdata, read/write kind
// in s_tuser) yields exactly one result on the m side: frame, offset and, on
// a miss, a fill request for the new page plus a flush request for the old
// page when the replaced frame was dirty. After reset the block sweeps the
// descriptor ram to zero with s_tready low. An access to the most recently
// looked-up page skips the scan (a write does a read-modify-write of the
// dirty flag). Any other access scans the descriptor ram one entry per cycle
// through a single ram read port and one page comparator: a hit ends the
// scan at the matching frame, a miss ends it after the last frame. One access
// is in work at a time; the result register lets the next access start while
// a result waits.
module page_frame_translation_round_robin_unit #(
	parameter int FRAMES    = pftr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = pftr_pkg::PAGE_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [pftr_pkg::S_TDATA_W-1:0]   s_tdata,   // address[26:0], zero pad
	input  logic                             s_tuser,   // action (1 = write)
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [pftr_pkg::M_TDATA_W-1:0]   m_tdata    // frame, offset, flush_request,
	                                                    // flush_page, fill_request,
	                                                    // fill_page, zero pad
);

	localparam int FW = $clog2(FRAMES);

	logic                res_valid;
	logic                res_ready;
	pftr_pkg::result_t   res;
	logic [FW-1:0]       mem_rd_addr;
	pftr_pkg::desc_t     mem_rd_data;
	logic                mem_wr_en;
	logic [FW-1:0]       mem_wr_addr;
	pftr_pkg::desc_t     mem_wr_data;
	logic                m_tvalid_q;
	pftr_pkg::result_t   m_res_q;

	assign res_ready = !m_tvalid_q || m_tready;

	pftr_seq #(
		.FRAMES    (FRAMES),
		.PAGE_BITS (PAGE_BITS),
		.FW        (FW)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.in_action   (s_tuser),
		.in_address  (s_tdata[pftr_pkg::ADDR_W-1:0]),
		.res_valid   (res_valid),
		.res_ready   (res_ready),
		.res         (res),
		.mem_rd_addr (mem_rd_addr),
		.mem_rd_data (mem_rd_data),
		.mem_wr_en   (mem_wr_en),
		.mem_wr_addr (mem_wr_addr),
		.mem_wr_data (mem_wr_data)
	);

	pftr_desc_ram #(
		.DEPTH (FRAMES),
		.AW    (FW)
	) u_desc_ram (
		.clk     (clk),
		.rd_addr (mem_rd_addr),
		.rd_data (mem_rd_data),
		.wr_en   (mem_wr_en),
		.wr_addr (mem_wr_addr),
		.wr_data (mem_wr_data)
	);

	// output register parts the result side from the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_res_q    <= '0;
		end else begin
			if (res_valid && res_ready) begin
				m_tvalid_q <= 1'b1;
				m_res_q    <= res;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(pftr_pkg::M_TDATA_W - pftr_pkg::RESULT_W)'(0), m_res_q};

endmodule

// ----- rtl/core/pftr_checker.sv -----
module pftr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_tvalid,
	input logic                             s_tready,
	input logic                             m_tvalid,
	input logic                             m_tready,
	input logic [pftr_pkg::M_TDATA_W-1:0]   m_tdata
);

	pftr_pkg::result_t res;

	assign res = m_tdata[pftr_pkg::RESULT_W-1:0];

	// one access in work at a time
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after a transfer");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");

	// a result is produced only by the sequencer, which is never idle then
	a_result_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result appeared while sequencer was idle");

	// a hit carries no fill and no flush
	a_hit_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.fill_request |->
			!res.flush_request && res.fill_page == '0 && res.flush_page == '0)
		else $error("hit result carries a flush or fill");

	a_clean_no_flush_page: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !res.flush_request |-> res.flush_page == '0)
		else $error("flush page set without a flush request");

endmodule

bind page_frame_translation_round_robin_unit pftr_checker u_pftr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
